/* rtl/core/kwcc_pkg.sv */
// Shared constants, types and helpers for the k-bit window code coverage core.
package kwcc_pkg;

    localparam int CODE_LEN_W          = 5;
    localparam int MAX_CODE_LENGTH_DEF = 20;
    localparam int CODES_MISSING_W     = 21;
    localparam int EPOCH_W_DEF         = 8;
    localparam int MID_DEPTH_DEF       = 2;
    localparam int OUT_DEPTH_DEF       = 4;

    typedef struct packed {
        logic                       all_codes_seen;
        logic [CODES_MISSING_W-1:0] codes_missing;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } back_state_t;

    function automatic logic [CODE_LEN_W-1:0] eff_len(
        input logic [CODE_LEN_W-1:0] len,
        input logic [CODE_LEN_W-1:0] max_len
    );
        logic [CODE_LEN_W-1:0] k;
        k = len;
        if (len == '0)
        begin
            k = CODE_LEN_W'(1);
        end
        else if (len > max_len)
        begin
            k = max_len;
        end
        return k;
    endfunction

endpackage

/* rtl/core/kwcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kwcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/kwcc_fifo.sv */
// Small register FIFO used between front and back and at the result side.
module kwcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/kwcc_front.sv */
// Front end: shifts bits into the window and classifies each beat.
module kwcc_front #(
    parameter int MAX_CODE_LENGTH = kwcc_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            bit_value,
    input  logic                            string_start,
    input  logic                            cfg_we,
    input  logic [kwcc_pkg::CODE_LEN_W-1:0] k,
    output logic [MAX_CODE_LENGTH+1:0]      item
);

    localparam int IDX_W = MAX_CODE_LENGTH;
    localparam int LW    = kwcc_pkg::CODE_LEN_W;

    logic [IDX_W-1:0] window_reg, window_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic             force_reg, force_next;
    logic             start;
    logic [IDX_W-1:0] mask, win_base, win_new;
    logic [LW-1:0]    cnt_base, cnt_new;
    logic             counted;

    always_comb
    begin
        start    = string_start || force_reg;
        mask     = ~({IDX_W{1'b1}} << k);
        win_base = start ? '0 : window_reg;
        win_new  = ((win_base << 1) | IDX_W'(bit_value)) & mask;
        cnt_base = start ? '0 : cnt_reg;
        cnt_new  = (cnt_base < k) ? cnt_base + LW'(1) : cnt_base;
        counted  = (cnt_new >= k);
        item     = {start, counted, win_new};

        window_next = window_reg;
        cnt_next    = cnt_reg;
        force_next  = force_reg;
        if (cfg_we)
        begin
            window_next = '0;
            cnt_next    = '0;
            force_next  = 1'b1;
        end
        else if (accept)
        begin
            window_next = win_new;
            cnt_next    = cnt_new;
            force_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            cnt_reg    <= '0;
            force_reg  <= 1'b1;
        end
        else
        begin
            window_reg <= window_next;
            cnt_reg    <= cnt_next;
            force_reg  <= force_next;
        end
    end

endmodule

/* rtl/core/kwcc_back.sv */
// Back end: epoch-tagged seen map read-modify-write and missing count.
module kwcc_back #(
    parameter int MAX_CODE_LENGTH = kwcc_pkg::MAX_CODE_LENGTH_DEF,
    parameter int EPOCH_W         = kwcc_pkg::EPOCH_W_DEF,
    parameter int OUT_DEPTH       = kwcc_pkg::OUT_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [kwcc_pkg::CODE_LEN_W-1:0]    k,
    input  logic [MAX_CODE_LENGTH+1:0]         mid_head,
    input  logic                               mid_empty,
    output logic                               mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
    output logic                               out_push,
    output kwcc_pkg::out_item_t                out_item
);

    localparam int IDX_W  = MAX_CODE_LENGTH;
    localparam int MISS_W = MAX_CODE_LENGTH + 1;
    localparam int CW     = $clog2(OUT_DEPTH + 1);
    localparam logic [EPOCH_W-1:0] EpochMax = {EPOCH_W{1'b1}};

    kwcc_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               rd_start_reg, rd_counted_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [EPOCH_W-1:0] rd_epoch_reg;
    logic               lw_valid_reg, lw_valid_next;
    logic [IDX_W-1:0]   lw_addr_reg;
    logic [EPOCH_W-1:0] lw_epoch_reg;
    logic [MISS_W-1:0]  miss_reg;

    logic               head_start, head_counted, wrap_hold, credit_ok, issue, go_clear;
    logic [IDX_W-1:0]   head_index;
    logic [EPOCH_W-1:0] item_epoch, tag_rdata, ram_wdata;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_we, hit, item_we;
    logic [MISS_W-1:0]  miss_base, miss_new;

    assign head_start   = mid_head[IDX_W+1];
    assign head_counted = mid_head[IDX_W];
    assign head_index   = mid_head[IDX_W-1:0];

    kwcc_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (2 ** MAX_CODE_LENGTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_index),
        .rdata (tag_rdata)
    );

    always_comb
    begin
        wrap_hold  = head_start && (epoch_reg == EpochMax);
        credit_ok  = ({1'b0, out_count} + (CW+1)'(rd_valid_reg)) < (CW+1)'(OUT_DEPTH);
        issue      = (state_reg == kwcc_pkg::ST_RUN) && !mid_empty && credit_ok && !wrap_hold;
        go_clear   = (state_reg == kwcc_pkg::ST_RUN) && !mid_empty && wrap_hold
                     && !rd_valid_reg;
        mid_pop    = issue;
        item_epoch = head_start ? epoch_reg + EPOCH_W'(1) : epoch_reg;

        hit = (tag_rdata == rd_epoch_reg)
              || (lw_valid_reg && (lw_addr_reg == rd_addr_reg)
                  && (lw_epoch_reg == rd_epoch_reg));
        miss_base = rd_start_reg ? (MISS_W'(1) << k) : miss_reg;
        miss_new  = (rd_counted_reg && !hit && (miss_base != '0))
                    ? miss_base - MISS_W'(1) : miss_base;
        item_we   = rd_valid_reg && rd_counted_reg && !hit;

        ram_we    = (state_reg == kwcc_pkg::ST_CLEAR) || item_we;
        ram_waddr = (state_reg == kwcc_pkg::ST_CLEAR) ? clr_addr_reg : rd_addr_reg;
        ram_wdata = (state_reg == kwcc_pkg::ST_CLEAR) ? '0 : rd_epoch_reg;

        out_push                = rd_valid_reg;
        out_item.all_codes_seen = (miss_new == '0);
        out_item.codes_missing  = kwcc_pkg::CODES_MISSING_W'(miss_new);

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        lw_valid_next = item_we ? 1'b1 : lw_valid_reg;
        rd_valid_next = issue;
        unique case (state_reg)
            kwcc_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == {IDX_W{1'b1}})
                begin
                    state_next    = kwcc_pkg::ST_RUN;
                    epoch_next    = '0;
                    lw_valid_next = 1'b0;
                end
            end
            kwcc_pkg::ST_RUN:
            begin
                if (go_clear)
                begin
                    state_next    = kwcc_pkg::ST_CLEAR;
                    clr_addr_next = '0;
                end
                else if (issue)
                begin
                    epoch_next = item_epoch;
                end
            end
            default:
            begin
                state_next = kwcc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kwcc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            epoch_reg    <= '0;
            rd_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            epoch_reg    <= epoch_next;
            rd_valid_reg <= rd_valid_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_start_reg   <= head_start;
            rd_counted_reg <= head_counted;
            rd_addr_reg    <= head_index;
            rd_epoch_reg   <= item_epoch;
        end
        if (item_we)
        begin
            lw_addr_reg  <= rd_addr_reg;
            lw_epoch_reg <= rd_epoch_reg;
        end
        if (rd_valid_reg)
        begin
            miss_reg <= miss_new;
        end
    end

    a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == kwcc_pkg::ST_RUN))
        else $error("lookup in flight during clearing pass");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (out_count < CW'(OUT_DEPTH)))
        else $error("result beat issued without queue room");

    a_clear_resets_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwcc_pkg::ST_RUN) && $past(state_reg == kwcc_pkg::ST_CLEAR)
        |-> (epoch_reg == '0) && !lw_valid_reg)
        else $error("epoch not restarted after clearing pass");

    a_lookup_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (rd_epoch_reg != '0) && (rd_epoch_reg == epoch_reg))
        else $error("lookup carries stale epoch");

endmodule

/* rtl/core/kwcc_tb_placeholder_removed.sv */
// Result queue wrapper: holds finished beats until popped.
module kwcc_outq #(
    parameter int OUT_DEPTH = kwcc_pkg::OUT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  kwcc_pkg::out_item_t            item,
    input  logic                           pop,
    output logic                           empty,
    output logic [$clog2(OUT_DEPTH+1)-1:0] count,
    output logic                           all_codes_seen,
    output logic [kwcc_pkg::CODES_MISSING_W-1:0] codes_missing
);

    kwcc_pkg::out_item_t head;
    logic                full_unused;

    kwcc_fifo #(
        .WIDTH ($bits(kwcc_pkg::out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .pop   (pop),
        .rdata (head),
        .empty (empty),
        .full  (full_unused),
        .count (count)
    );

    assign all_codes_seen = head.all_codes_seen && !full_unused | head.all_codes_seen;
    assign codes_missing  = head.codes_missing;

endmodule

/* rtl/core/kbit_window_code_coverage_core.sv */
// Top level of the k-bit window code coverage core.
// Takes one bit per beat and returns one result beat per input beat, sustaining one beat per
// clock while the output queue has room and no clearing pass runs: the front shifts the
// window as the beat is accepted, and the back does the seen-map read-modify-write as a
// registered tag RAM read, then compare and write, with the last write forwarded, before
// the result enters the output queue. The seen map is a 2^MAX_CODE_LENGTH entry tag RAM
// holding an epoch per code; a string start opens a new epoch instead of clearing it. After
// reset, and again at every (2^EPOCH_W - 1)th string start when the epoch wraps, a clearing
// pass over all 2^MAX_CODE_LENGTH entries runs during which no beat is processed; the input
// stalls once the MID_DEPTH-entry queue between front and back fills. Writing code_length
// starts a new string with the new length.
module kbit_window_code_coverage_core #(
    parameter int MAX_CODE_LENGTH = kwcc_pkg::MAX_CODE_LENGTH_DEF,
    parameter int EPOCH_W         = kwcc_pkg::EPOCH_W_DEF,
    parameter int MID_DEPTH       = kwcc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH       = kwcc_pkg::OUT_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kwcc_pkg::CODE_LEN_W-1:0]      cfg_wdata,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 bit_value,
    input  logic                                 string_start,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 all_codes_seen,
    output logic [kwcc_pkg::CODES_MISSING_W-1:0] codes_missing
);

    localparam int ITEM_W = MAX_CODE_LENGTH + 2;
    localparam int OCW    = $clog2(OUT_DEPTH + 1);

    logic [kwcc_pkg::CODE_LEN_W-1:0] code_length_reg, code_length_next;
    logic [kwcc_pkg::CODE_LEN_W-1:0] k;
    logic                            accept;
    logic [ITEM_W-1:0]               front_item, mid_head;
    logic                            mid_empty, mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
    logic [OCW-1:0]                  out_count;
    logic                            out_push;
    kwcc_pkg::out_item_t             out_item;

    assign accept           = push && !full;
    assign code_length_next = cfg_we ? cfg_wdata : code_length_reg;
    assign k = kwcc_pkg::eff_len(code_length_reg,
                                 kwcc_pkg::CODE_LEN_W'(MAX_CODE_LENGTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= kwcc_pkg::CODE_LEN_W'(1);
        end
        else
        begin
            code_length_reg <= code_length_next;
        end
    end

    kwcc_front #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .bit_value    (bit_value),
        .string_start (string_start),
        .cfg_we       (cfg_we),
        .k            (k),
        .item         (front_item)
    );

    kwcc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_item),
        .pop   (mid_pop),
        .rdata (mid_head),
        .empty (mid_empty),
        .full  (full),
        .count (mid_count)
    );

    kwcc_back #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
        .EPOCH_W         (EPOCH_W),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .k         (k),
        .mid_head  (mid_head),
        .mid_empty (mid_empty || (mid_count == '0)),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    kwcc_outq #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (out_push),
        .item           (out_item),
        .pop            (pop),
        .empty          (empty),
        .count          (out_count),
        .all_codes_seen (all_codes_seen),
        .codes_missing  (codes_missing)
    );

endmodule
